// ----- hw/rtl/qtl_pkg.sv -----
// qtl_pkg: shared types, constants and byte classification functions of the query token lexer
`timescale 1ns / 1ps
package qtl_pkg;

  // lexer modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_BARE  = 3'd1;
  localparam logic [2:0] MODE_QUOTE = 3'd2;
  localparam logic [2:0] MODE_ESC   = 3'd3;
  localparam logic [2:0] MODE_HEX1  = 3'd4;
  localparam logic [2:0] MODE_HEX2  = 3'd5;
  localparam logic [2:0] MODE_LEAD  = 3'd6;
  localparam logic [2:0] MODE_HOLD  = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNTERM   = 3'd1;
  localparam logic [2:0] ERR_ESC_END  = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
  localparam logic [2:0] ERR_HEX_ZERO = 3'd4;

  // characters
  localparam logic [7:0] CH_END    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // number of results one byte can cause
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       token_end;
    logic       token_quoted;
    logic       query_end;
    logic [2:0] error_code;
    logic       last_of_run;
  } result_t;

  // results of one byte from the lexer core
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } lex_out_t;

  function automatic logic is_separator(input logic [7:0] b);
    return (b <= CH_SPACE) || (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_COMMA);
  endfunction

  function automatic logic is_sjis_lead(input logic [7:0] b);
    return (b inside {[8'h81:8'h9F]}) || (b inside {[8'hE0:8'hFC]});
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39]}) || (b inside {[8'h61:8'h66]}) ||
           (b inside {[8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [3:0] v;
    if (b inside {[8'h30:8'h39]}) begin
      v = b[3:0];
    end else begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic result_t mk_result(input logic [7:0] data, input logic valid,
                                        input logic tend, input logic quoted,
                                        input logic qend, input logic [2:0] err);
    result_t r;
    r.data_byte    = data;
    r.byte_valid   = valid;
    r.token_end    = tend;
    r.token_quoted = quoted;
    r.query_end    = qend;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/qtl_in_if.sv -----
// qtl_in_if: input byte channel of the query token lexer
`timescale 1ns / 1ps
interface qtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/qtl_out_if.sv -----
// qtl_out_if: result channel of the query token lexer
`timescale 1ns / 1ps
interface qtl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       token_end;
  logic       token_quoted;
  logic       query_end;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output data_byte, output byte_valid, output token_end,
                  output token_quoted, output query_end, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input token_end,
                input token_quoted, input query_end, input error_code,
                input last_of_run, output ready);
endinterface

// ----- hw/rtl/query_token_lexer.sv -----
// query_token_lexer: top level of the query token lexer
//
// Splits a query, fed one byte per word on in_ch, into token result words on
// out_ch. Byte 0 ends the query. Both channels use valid/ready; a word moves
// at a rising edge where both are high.
// Each result word carries the translated token byte and flags for token end,
// quoted token, query end, an error code and last_of_run, which marks the last
// word caused by one input byte.
// A byte taken from in_ch goes through the input register, then the lexer logic
// into the result register, before its first result word shows on out_ch.
// Throughput: one byte per cycle while out_ch takes a word per cycle; a byte
// that yields two results (end byte after a bare token) holds the input until
// the single result register has drained its second slot.
// Bytes that yield no result pass without using the result channel.
// Reset (rst_n low, synchronous) empties the input and result registers and
// returns the lexer to between tokens.
// When out_ch stalls, the result register and its second slot hold their words
// and in_ch takes bytes until the input register holds one that needs a result.
`timescale 1ns / 1ps
module query_token_lexer (
  input  logic      clk,
  input  logic      rst_n,
  qtl_in_if.sink    in_ch,
  qtl_out_if.source out_ch
);
  import qtl_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       consume;
  logic       can_load;
  lex_out_t   lex;

  // the registered byte is used when it causes no result or the output has room
  assign consume     = in_valid_r && (lex.count == CNT_NONE || can_load);
  assign in_ch.ready = !in_valid_r || consume;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.in_byte;
    end
  end

  qtl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_i (byte_r),
    .take_i (consume),
    .lex_o  (lex)
  );

  qtl_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (consume && lex.count != CNT_NONE),
    .lex_i      (lex),
    .can_load_o (can_load),
    .out_ch     (out_ch)
  );

  // a byte that needs the output is never used while the output is full
  a_consume_room: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && lex.count != CNT_NONE) |-> can_load)
    else $error("byte used without output room");

  // a held byte is not replaced before it is used
  a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !consume) |=> (in_valid_r && $stable(byte_r)))
    else $error("held byte lost");

  // a byte is only used when one is held
  a_consume_valid: assert property (@(posedge clk) disable iff (!rst_n)
    consume |-> in_valid_r)
    else $error("consume without a held byte");

endmodule

// ----- hw/rtl/qtl_core.sv -----
// qtl_core: lexer mode register and the per-byte result logic
`timescale 1ns / 1ps
module qtl_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        byte_i,
  input  logic              take_i,
  output qtl_pkg::lex_out_t lex_o
);
  import qtl_pkg::*;

  logic [2:0] mode_r, mode_nxt;
  logic [3:0] hex_hi_r, hex_hi_nxt;
  lex_out_t   lex;
  logic [7:0] esc_val;
  logic [7:0] hex_val;

  // escape translation and hex assembly
  always_comb begin
    case (byte_i)
      CH_T:    esc_val = CH_TAB;
      CH_N:    esc_val = CH_LF;
      CH_R:    esc_val = CH_CR;
      CH_S:    esc_val = CH_SPACE;
      default: esc_val = byte_i;
    endcase
    hex_val = {hex_hi_r, hex_nibble(byte_i)};
  end

  // results and next mode for the current word
  always_comb begin
    lex        = '0;
    mode_nxt   = mode_r;
    hex_hi_nxt = hex_hi_r;
    case (mode_r)
      MODE_IDLE: begin
        if (byte_i == CH_END) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ERR_NONE);
        end else if (byte_i == CH_QUOTE) begin
          mode_nxt = MODE_QUOTE;
        end else if (!is_separator(byte_i)) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(byte_i, 1'b1, 1'b0, 1'b0, 1'b0, ERR_NONE);
          mode_nxt  = MODE_BARE;
        end
      end
      MODE_BARE: begin
        if (byte_i == CH_END) begin
          lex.count  = CNT_TWO;
          lex.first  = mk_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE);
          lex.second = mk_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ERR_NONE);
          mode_nxt   = MODE_IDLE;
        end else if (is_separator(byte_i)) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE);
          mode_nxt  = MODE_IDLE;
        end else begin
          lex.count = CNT_ONE;
          lex.first = mk_result(byte_i, 1'b1, 1'b0, 1'b0, 1'b0, ERR_NONE);
        end
      end
      MODE_QUOTE: begin
        if (byte_i == CH_END) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ERR_UNTERM);
          mode_nxt  = MODE_IDLE;
        end else if (byte_i == CH_QUOTE) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, ERR_NONE);
          mode_nxt  = MODE_IDLE;
        end else if (byte_i == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          lex.count = CNT_ONE;
          lex.first = mk_result(byte_i, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
          if (is_sjis_lead(byte_i)) begin
            mode_nxt = MODE_LEAD;
          end
        end
      end
      MODE_LEAD: begin
        lex.count = CNT_ONE;
        if (byte_i == CH_END) begin
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ERR_UNTERM);
          mode_nxt  = MODE_IDLE;
        end else begin
          lex.first = mk_result(byte_i, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
          mode_nxt  = MODE_QUOTE;
        end
      end
      MODE_ESC: begin
        if (byte_i == CH_END) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ERR_ESC_END);
          mode_nxt  = MODE_IDLE;
        end else if (byte_i == CH_X) begin
          mode_nxt = MODE_HEX1;
        end else begin
          lex.count = CNT_ONE;
          lex.first = mk_result(esc_val, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
          mode_nxt  = MODE_QUOTE;
        end
      end
      MODE_HEX1: begin
        if (!is_hex(byte_i)) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b1, byte_i == CH_END, ERR_BAD_HEX);
          mode_nxt  = (byte_i == CH_END) ? MODE_IDLE : MODE_HOLD;
        end else begin
          hex_hi_nxt = hex_nibble(byte_i);
          mode_nxt   = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        lex.count = CNT_ONE;
        if (!is_hex(byte_i)) begin
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b1, byte_i == CH_END, ERR_BAD_HEX);
          mode_nxt  = (byte_i == CH_END) ? MODE_IDLE : MODE_HOLD;
        end else if (hex_val == 8'h00) begin
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ERR_HEX_ZERO);
          mode_nxt  = MODE_HOLD;
        end else begin
          lex.first = mk_result(hex_val, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
          mode_nxt  = MODE_QUOTE;
        end
      end
      default: begin
        // holding after an error until the end word
        if (byte_i == CH_END) begin
          lex.count = CNT_ONE;
          lex.first = mk_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ERR_NONE);
          mode_nxt  = MODE_IDLE;
        end
      end
    endcase
    lex.first.last_of_run  = (lex.count == CNT_ONE);
    lex.second.last_of_run = (lex.count == CNT_TWO);
  end

  assign lex_o = lex;

  // mode and hex nibble registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      hex_hi_r <= 4'h0;
    end else if (take_i) begin
      mode_r   <= mode_nxt;
      hex_hi_r <= hex_hi_nxt;
    end
  end

  // error results never carry a token byte
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (lex.count != CNT_NONE && lex.first.error_code != ERR_NONE) |-> !lex.first.byte_valid)
    else $error("error result carries a token byte");

  // two results only when a bare token meets the end word
  a_two_only_bare: assert property (@(posedge clk) disable iff (!rst_n)
    (lex.count == CNT_TWO) |-> (mode_r == MODE_BARE && byte_i == CH_END))
    else $error("double result outside bare token end");

  // the hold mode is entered only through an error result
  a_hold_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (take_i && mode_r != MODE_HOLD && mode_nxt == MODE_HOLD) |->
      (lex.first.error_code == ERR_BAD_HEX || lex.first.error_code == ERR_HEX_ZERO))
    else $error("hold mode entered without an error");

endmodule

// ----- hw/rtl/qtl_out_buf.sv -----
// qtl_out_buf: result register with a second slot for the double-result word
`timescale 1ns / 1ps
module qtl_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  qtl_pkg::lex_out_t lex_i,
  output logic              can_load_o,
  qtl_out_if.source         out_ch
);
  import qtl_pkg::*;

  result_t out_r;
  result_t pend_r;
  logic    out_valid_r;
  logic    pend_valid_r;
  logic    out_fire;

  assign out_fire   = out_valid_r && out_ch.ready;
  assign can_load_o = !pend_valid_r && (!out_valid_r || out_ch.ready);

  // control: output slot and pending second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (load_i) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= (lex_i.count == CNT_TWO);
    end else if (out_fire) begin
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_i) begin
      out_r  <= lex_i.first;
      pend_r <= lex_i.second;
    end else if (out_fire && pend_valid_r) begin
      out_r <= pend_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_byte    = out_r.data_byte;
  assign out_ch.byte_valid   = out_r.byte_valid;
  assign out_ch.token_end    = out_r.token_end;
  assign out_ch.token_quoted = out_r.token_quoted;
  assign out_ch.query_end    = out_r.query_end;
  assign out_ch.error_code   = out_r.error_code;
  assign out_ch.last_of_run  = out_r.last_of_run;

  // pending slot is only ever filled behind a valid output word
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending result without output result");

  // a new load never overwrites a waiting second result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> !pend_valid_r)
    else $error("load while second result pending");

  // the word ahead of a pending result is not the last of its run
  a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !out_r.last_of_run)
    else $error("last_of_run ahead of pending result");

  // a double load leaves the second result pending
  a_double_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (load_i && lex_i.count == CNT_TWO) |=> pend_valid_r)
    else $error("second result lost");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench of the query token lexer, with directed and random queries
`timescale 1ns / 1ps
module tb_top;
  import qtl_pkg::*;

  // character data used to build queries, random byte budget and report limit
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam int         RANDOM_BYTES = 450;
  localparam int         MAX_REPORTS  = 40;

  logic clk = 1'b0;
  logic rst_n;

  qtl_in_if  in_ch ();
  qtl_out_if out_ch ();

  query_token_lexer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted lexer state
  logic [2:0] lx_mode;
  logic [3:0] lx_hi_nib;
  logic       lx_quoted;

  result_t    lex_words_due[$];
  logic [7:0] query_bytes[$];

  int mismatches = 0;
  int n_bytes = 0;
  int n_queries = 0;
  int n_words = 0;
  int n_fault_words = 0;
  int burst_left = 0;
  int rx_phase_left = 0;
  int rx_style = 0;
  int rx_tick = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // byte classes
  function automatic logic sep_byte(input logic [7:0] b);
    return (b <= CH_SPACE) || (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_COMMA);
  endfunction

  function automatic logic lead_byte(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  function automatic logic hex_digit_ok(input logic [7:0] b);
    return (b >= CH_DIGIT0 && b <= CH_DIGIT0 + 8'd9) ||
           (b >= CH_LOWER_A && b <= CH_LOWER_A + 8'd5) ||
           (b >= CH_UPPER_A && b <= CH_UPPER_A + 8'd5);
  endfunction

  function automatic logic [3:0] hex_digit_val(input logic [7:0] b);
    logic [7:0] v;
    if (b <= CH_DIGIT0 + 8'd9) begin
      v = b - CH_DIGIT0;
    end else if (b >= CH_LOWER_A) begin
      v = b - CH_LOWER_A + 8'd10;
    end else begin
      v = b - CH_UPPER_A + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic result_t lex_word(input logic [7:0] data, input logic valid,
                                       input logic tend, input logic quoted,
                                       input logic qend, input logic [2:0] err);
    result_t w;
    w.data_byte    = data;
    w.byte_valid   = valid;
    w.token_end    = tend;
    w.token_quoted = quoted;
    w.query_end    = qend;
    w.error_code   = err;
    w.last_of_run  = 1'b0;
    return w;
  endfunction

  // fault inside a quoted token: the end byte closes the query, otherwise hold
  function automatic result_t quote_fault(input logic [7:0] b, input logic [2:0] err);
    if (b == CH_END) begin
      lx_mode = MODE_IDLE;
      return lex_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, err);
    end
    lx_mode = MODE_HOLD;
    return lex_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, err);
  endfunction

  // expected result words of one accepted byte
  function automatic void lex_predict(input logic [7:0] b);
    result_t    w[0:1];
    int         n;
    logic [7:0] v;
    n = 0;
    case (lx_mode)
      MODE_IDLE: begin
        if (b == CH_END) begin
          w[0] = lex_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ERR_NONE);
          n = 1;
        end else if (b == CH_QUOTE) begin
          lx_quoted = 1'b1;
          lx_mode = MODE_QUOTE;
        end else if (!sep_byte(b)) begin
          lx_quoted = 1'b0;
          w[0] = lex_word(b, 1'b1, 1'b0, 1'b0, 1'b0, ERR_NONE);
          n = 1;
          lx_mode = MODE_BARE;
        end
      end
      MODE_BARE: begin
        if (b == CH_END) begin
          w[0] = lex_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE);
          w[1] = lex_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ERR_NONE);
          n = 2;
          lx_mode = MODE_IDLE;
        end else if (sep_byte(b)) begin
          w[0] = lex_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE);
          n = 1;
          lx_mode = MODE_IDLE;
        end else begin
          w[0] = lex_word(b, 1'b1, 1'b0, 1'b0, 1'b0, ERR_NONE);
          n = 1;
        end
      end
      MODE_QUOTE: begin
        n = 1;
        if (b == CH_END) begin
          w[0] = quote_fault(b, ERR_UNTERM);
        end else if (b == CH_QUOTE) begin
          w[0] = lex_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, ERR_NONE);
          lx_mode = MODE_IDLE;
        end else if (b == CH_BSLASH) begin
          n = 0;
          lx_mode = MODE_ESC;
        end else begin
          w[0] = lex_word(b, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
          if (lead_byte(b)) lx_mode = MODE_LEAD;
        end
      end
      MODE_LEAD: begin
        n = 1;
        if (b == CH_END) begin
          w[0] = quote_fault(b, ERR_UNTERM);
        end else begin
          w[0] = lex_word(b, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
          lx_mode = MODE_QUOTE;
        end
      end
      MODE_ESC: begin
        n = 1;
        if (b == CH_END) begin
          w[0] = quote_fault(b, ERR_ESC_END);
        end else if (b == CH_X) begin
          n = 0;
          lx_mode = MODE_HEX1;
        end else begin
          case (b)
            CH_T:    v = CH_TAB;
            CH_N:    v = CH_LF;
            CH_R:    v = CH_CR;
            CH_S:    v = CH_SPACE;
            default: v = b;
          endcase
          w[0] = lex_word(v, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
          lx_mode = MODE_QUOTE;
        end
      end
      MODE_HEX1: begin
        if (!hex_digit_ok(b)) begin
          w[0] = quote_fault(b, ERR_BAD_HEX);
          n = 1;
        end else begin
          lx_hi_nib = hex_digit_val(b);
          lx_mode = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        n = 1;
        if (!hex_digit_ok(b)) begin
          w[0] = quote_fault(b, ERR_BAD_HEX);
        end else begin
          v = {lx_hi_nib, hex_digit_val(b)};
          if (v == 8'h00) begin
            w[0] = quote_fault(b, ERR_HEX_ZERO);
          end else begin
            w[0] = lex_word(v, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE);
            lx_mode = MODE_QUOTE;
          end
        end
      end
      default: begin
        // holding after a fault until the end byte
        if (b == CH_END) begin
          w[0] = lex_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ERR_NONE);
          n = 1;
          lx_mode = MODE_IDLE;
        end
      end
    endcase
    if (n > 0) w[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) lex_words_due.push_back(w[i]);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // send one byte, in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    lex_predict(b);
    n_bytes++;
  endtask

  task automatic send_query();
    foreach (query_bytes[i]) send_byte(query_bytes[i]);
    n_queries++;
    query_bytes.delete();
  endtask

  // receiver stalls in phases: always ready, coin toss, or one cycle in four
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_phase_left = $urandom_range(4, 48);
      rx_style = $urandom_range(0, 2);
    end
    rx_phase_left--;
    rx_tick++;
    case (rx_style)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (rx_tick % 4 == 0);
    endcase
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_words
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data_byte    = out_ch.data_byte;
      got.byte_valid   = out_ch.byte_valid;
      got.token_end    = out_ch.token_end;
      got.token_quoted = out_ch.token_quoted;
      got.query_end    = out_ch.query_end;
      got.error_code   = out_ch.error_code;
      got.last_of_run  = out_ch.last_of_run;
      n_words++;
      if (got.error_code != ERR_NONE) n_fault_words++;
      if (lex_words_due.size() == 0) begin
        report_mismatch("result word with none expected", got, 0);
      end else begin
        want = lex_words_due.pop_front();
        if (got.data_byte !== want.data_byte)
          report_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
        if (got.token_end !== want.token_end)
          report_mismatch("token_end", got.token_end, want.token_end);
        if (got.token_quoted !== want.token_quoted)
          report_mismatch("token_quoted", got.token_quoted, want.token_quoted);
        if (got.query_end !== want.query_end)
          report_mismatch("query_end", got.query_end, want.query_end);
        if (got.error_code !== want.error_code)
          report_mismatch("error_code", got.error_code, want.error_code);
        if (got.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
      end
    end
  end

  // random byte pickers
  function automatic logic [7:0] rand_sep();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(1, 32));
      1:       return CH_LPAREN;
      2:       return CH_RPAREN;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] rand_bare();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255));
    while (c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] rand_not_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (hex_digit_ok(c));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_DIGIT0 + 8'(v);
    if ($urandom_range(0, 1) == 1) return CH_UPPER_A + 8'(v) - 8'd10;
    return CH_LOWER_A + 8'(v) - 8'd10;
  endfunction

  // quoted token with random content and escapes
  task automatic push_quoted_token();
    logic [7:0] c;
    logic [3:0] hi;
    logic [3:0] lo;
    query_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          c = rand_plain();
          query_bytes.push_back(c);
          if (lead_byte(c)) query_bytes.push_back(8'($urandom_range(1, 255)));
        end
        5, 6: begin
          query_bytes.push_back(CH_BSLASH);
          case ($urandom_range(0, 4))
            0: c = CH_T;
            1: c = CH_N;
            2: c = CH_R;
            3: c = CH_S;
            default: begin
              do c = 8'($urandom_range(1, 255));
              while (c == CH_X);
            end
          endcase
          query_bytes.push_back(c);
        end
        7, 8: begin
          hi = 4'($urandom_range(0, 15));
          lo = 4'($urandom_range(0, 15));
          if (hi == 4'd0 && lo == 4'd0) lo = 4'd1;
          query_bytes.push_back(CH_BSLASH);
          query_bytes.push_back(CH_X);
          query_bytes.push_back(hex_char(hi));
          query_bytes.push_back(hex_char(lo));
        end
        default: begin
          // lead byte with a raw follower that would otherwise be special
          if ($urandom_range(0, 1) == 1) c = 8'($urandom_range(8'h81, 8'h9F));
          else c = 8'($urandom_range(8'hE0, 8'hFC));
          query_bytes.push_back(c);
          case ($urandom_range(0, 2))
            0:       query_bytes.push_back(CH_QUOTE);
            1:       query_bytes.push_back(CH_BSLASH);
            default: query_bytes.push_back(8'($urandom_range(1, 255)));
          endcase
        end
      endcase
    end
    query_bytes.push_back(CH_QUOTE);
  endtask

  // one random query, mostly well formed, sometimes broken
  task automatic build_query();
    int cut;
    query_bytes.delete();
    repeat ($urandom_range(0, 1)) query_bytes.push_back(rand_sep());
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 6)) query_bytes.push_back(rand_bare());
      end else begin
        push_quoted_token();
      end
      repeat ($urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 2))
        query_bytes.push_back(rand_sep());
    end
    query_bytes.push_back(CH_END);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          // cut short anywhere
          cut = $urandom_range(0, query_bytes.size() - 1);
          while (query_bytes.size() > cut) void'(query_bytes.pop_back());
          query_bytes.push_back(CH_END);
        end
        1: begin
          query_bytes.delete();
          repeat ($urandom_range(1, 10)) query_bytes.push_back(8'($urandom_range(1, 255)));
          query_bytes.push_back(CH_END);
        end
        2: begin
          // broken hex escape, then junk up to the end
          void'(query_bytes.pop_back());
          query_bytes.push_back(CH_SPACE);
          query_bytes.push_back(CH_QUOTE);
          query_bytes.push_back(CH_BSLASH);
          query_bytes.push_back(CH_X);
          case ($urandom_range(0, 2))
            0: query_bytes.push_back(rand_not_hex());
            1: begin
              query_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
              query_bytes.push_back(rand_not_hex());
            end
            default: begin
              query_bytes.push_back(CH_DIGIT0);
              query_bytes.push_back(CH_DIGIT0);
            end
          endcase
          repeat ($urandom_range(0, 5)) query_bytes.push_back(8'($urandom_range(1, 255)));
          query_bytes.push_back(CH_END);
        end
        default: begin
          cut = $urandom_range(0, query_bytes.size() - 1);
          query_bytes.insert(cut, 8'($urandom_range(1, 255)));
        end
      endcase
    end
  endtask

  // bare tokens, separators, a quote inside a bare token, end after a bare token
  task automatic test_bare_tokens();
    query_bytes = '{CH_SPACE, 8'hFF, CH_LPAREN, 8'h21, CH_QUOTE, CH_COMMA, 8'h7F, CH_END};
    send_query();
  endtask

  // every escape, an escaped quote and hex in both cases
  task automatic test_quoted_escapes();
    query_bytes = '{CH_QUOTE, CH_BSLASH, CH_T, CH_BSLASH, CH_N, CH_BSLASH, CH_R,
                    CH_BSLASH, CH_S, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_X, 8'h46, 8'h66,
                    CH_QUOTE, CH_END};
    send_query();
  endtask

  // empty quoted token, lead bytes copying special bytes, end after a lead byte
  task automatic test_quote_corners();
    query_bytes = '{CH_QUOTE, CH_QUOTE, CH_RPAREN, CH_QUOTE, 8'h81, CH_QUOTE, 8'h9F,
                    CH_BSLASH, 8'hE0, CH_END};
    send_query();
    query_bytes = '{CH_QUOTE, 8'h80, CH_END};
    send_query();
  endtask

  // escape cut by the end, hex cut by the end, bad hex with hold, escaped zero
  task automatic test_error_endings();
    query_bytes = '{CH_QUOTE, CH_BSLASH, CH_END};
    send_query();
    query_bytes = '{CH_QUOTE, CH_BSLASH, CH_X, 8'h41, CH_END};
    send_query();
    query_bytes = '{CH_QUOTE, CH_BSLASH, CH_X, 8'h67, CH_QUOTE, CH_END};
    send_query();
    query_bytes = '{CH_QUOTE, CH_BSLASH, CH_X, CH_DIGIT0, CH_DIGIT0, 8'h41, CH_END};
    send_query();
  endtask

  task automatic test_random_queries();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_query();
      sent += query_bytes.size();
      send_query();
    end
  endtask

  // reset, stimulus, drain and verdict
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    lx_mode = MODE_IDLE;
    lx_hi_nib = 4'd0;
    lx_quoted = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_bare_tokens();
    test_quoted_escapes();
    test_quote_corners();
    test_error_endings();
    test_random_queries();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (lex_words_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d queries, %0d bytes, %0d result words (%0d with an error code)",
             n_queries, n_bytes, n_words, n_fault_words);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("timeout with %0d result words still due", lex_words_due.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- query_token_lexer.f -----
hw/rtl/qtl_pkg.sv
hw/rtl/qtl_in_if.sv
hw/rtl/qtl_out_if.sv
hw/rtl/qtl_core.sv
hw/rtl/qtl_out_buf.sv
hw/rtl/query_token_lexer.sv
dv/tb_top.sv
